/* rtl/ray_plane_intersection_macros.svh */
// ----------------------------------------------------------------------------
// Ray/plane intersection assertion macros
// Property shorthands for the assertions in ray_plane_intersection.sv.
// ----------------------------------------------------------------------------
`ifndef RAY_PLANE_INTERSECTION_MACROS_SVH
`define RAY_PLANE_INTERSECTION_MACROS_SVH

// Same-cycle implication.
`define RPI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rpi_pkg.sv */
// ----------------------------------------------------------------------------
// Ray/plane intersection package
// Widths, register indexes and pipeline stage types.
// ----------------------------------------------------------------------------
package rpi_pkg;

  localparam int CoordW   = 32;
  localparam int NormW    = 17;
  localparam int ProdW    = 49;
  localparam int AccW     = 52;
  localparam int QuoW     = 31;
  localparam int DivSteps = 31;
  localparam int TProdW   = 64;
  localparam int SumW     = 50;
  localparam int CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } reg_index_t;

  // The ray faces the plane when N.D is at most this value (N.D < -0.001).
  localparam logic signed [AccW-1:0] FacingLimit = -52'sd2147484;
  localparam logic [CoordW-1:0] DistMax = 32'h7FFF_FFFF;
  localparam logic signed [NormW-1:0] NormalZReset = 17'sd32768;

  typedef struct packed {
    logic [2:0][CoordW-1:0] origin;
    logic [2:0][CoordW-1:0] dir;
  } ray_t;

  typedef struct packed {
    logic            valid;
    logic            hit;
    logic            sat;
    ray_t            ray;
    logic [AccW-1:0] ud;
    logic [AccW-1:0] rem;
    logic [QuoW-1:0] xbits;
    logic [QuoW-1:0] quo;
  } div_stage_t;

endpackage

/* rtl/rpi_ray_if.sv */
// ----------------------------------------------------------------------------
// Ray channel
// Valid/ready channel carrying one ray per transfer.
// ----------------------------------------------------------------------------
interface rpi_ray_if;
  logic                               valid;
  logic                               ready;
  logic signed [rpi_pkg::CoordW-1:0] origin_x;
  logic signed [rpi_pkg::CoordW-1:0] origin_y;
  logic signed [rpi_pkg::CoordW-1:0] origin_z;
  logic signed [rpi_pkg::CoordW-1:0] dir_x;
  logic signed [rpi_pkg::CoordW-1:0] dir_y;
  logic signed [rpi_pkg::CoordW-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

/* rtl/rpi_hit_if.sv */
// ----------------------------------------------------------------------------
// Hit channel
// Valid/ready channel carrying one intersection result per transfer.
// ----------------------------------------------------------------------------
interface rpi_hit_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic signed [rpi_pkg::CoordW-1:0] distance;
  logic signed [rpi_pkg::CoordW-1:0] point_x;
  logic signed [rpi_pkg::CoordW-1:0] point_y;
  logic signed [rpi_pkg::CoordW-1:0] point_z;
  logic signed [rpi_pkg::NormW-1:0]  surface_normal_x;
  logic signed [rpi_pkg::NormW-1:0]  surface_normal_y;
  logic signed [rpi_pkg::NormW-1:0]  surface_normal_z;

  modport source (output valid, hit, distance, point_x, point_y, point_z,
                  surface_normal_x, surface_normal_y, surface_normal_z,
                  input ready);
  modport sink (input valid, hit, distance, point_x, point_y, point_z,
                surface_normal_x, surface_normal_y, surface_normal_z,
                output ready);
endinterface

/* rtl/ray_plane_intersection.sv */
// ----------------------------------------------------------------------------
// Ray/plane intersection
// Tests rays against a one-sided plane and reports distance, point and normal.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Contents
//  ---------+-----+---------------------------------------------
//  ray      | in  | origin_x/y/z, dir_x/y/z
//  result   | out | hit, distance, point_x/y/z, surface_normal_x/y/z
//  cfg      | in  | cfg_we, cfg_index, cfg_data
//
//  One ray enters per cycle while the output is not stalled; the divider has 31 steps.
//  Reset is synchronous, clears all valid bits and sets the plane to normal (0, 0, NormalZReset), offset 0.
//  A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_plane_intersection (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rpi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rpi_pkg::CoordW-1:0]  cfg_data,
  rpi_ray_if.sink                      ray,
  rpi_hit_if.source                    result
);
  import rpi_pkg::*;

  logic signed [NormW-1:0]  normal_x, normal_y, normal_z;
  logic signed [CoordW-1:0] plane_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x     <= '0;
      normal_y     <= '0;
      normal_z     <= NormalZReset;
      plane_offset <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_NORMAL_X:     normal_x     <= cfg_data[NormW-1:0];
        REG_NORMAL_Y:     normal_y     <= cfg_data[NormW-1:0];
        REG_NORMAL_Z:     normal_z     <= cfg_data[NormW-1:0];
        REG_PLANE_OFFSET: plane_offset <= cfg_data;
      endcase
    end
  end

  logic advance;
  assign advance   = !result.valid || result.ready;
  assign ray.ready = advance;

  // Dot product terms.
  logic                    s1_valid;
  ray_t                    s1_ray;
  logic signed [ProdW-1:0] s1_nd0, s1_nd1, s1_nd2;
  logic signed [ProdW-1:0] s1_no0, s1_no1, s1_no2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= ray.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ray.origin <= {ray.origin_z, ray.origin_y, ray.origin_x};
      s1_ray.dir    <= {ray.dir_z, ray.dir_y, ray.dir_x};
      s1_nd0 <= normal_x * ray.dir_x;
      s1_nd1 <= normal_y * ray.dir_y;
      s1_nd2 <= normal_z * ray.dir_z;
      s1_no0 <= normal_x * ray.origin_x;
      s1_no1 <= normal_y * ray.origin_y;
      s1_no2 <= normal_z * ray.origin_z;
    end
  end

  // Sums: den = N.D, num = -(N.O + d).
  logic                   s2_valid;
  ray_t                   s2_ray;
  logic signed [AccW-1:0] s2_den, s2_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ray <= s1_ray;
      s2_den <= AccW'(s1_nd0) + AccW'(s1_nd1) + AccW'(s1_nd2);
      s2_num <= -(AccW'(s1_no0) + AccW'(s1_no1) + AccW'(s1_no2)
                  + (AccW'(plane_offset) <<< 15));
    end
  end

  // Hit test and divider setup, then one quotient bit per stage.
  div_stage_t      div_q [DivSteps+1];
  div_stage_t      div_init;
  logic [AccW-1:0] un;

  always_comb begin
    un             = AccW'(-s2_num);
    div_init.valid = s2_valid;
    div_init.hit   = (s2_den <= FacingLimit) && (s2_num <= 0);
    div_init.ray   = s2_ray;
    div_init.ud    = AccW'(-s2_den);
    div_init.rem   = un >> 15;
    div_init.sat   = (un >> 15) >= div_init.ud;
    div_init.xbits = {un[14:0], 16'b0};
    div_init.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_q[0].valid <= 1'b0;
    end else if (advance) begin
      div_q[0] <= div_init;
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    div_stage_t      nxt;
    logic [AccW-1:0] trial;
    logic            ge;

    always_comb begin
      nxt       = div_q[k-1];
      trial     = {div_q[k-1].rem[AccW-2:0], div_q[k-1].xbits[QuoW-1]};
      ge        = trial >= div_q[k-1].ud;
      nxt.rem   = ge ? trial - div_q[k-1].ud : trial;
      nxt.quo   = {div_q[k-1].quo[QuoW-2:0], ge};
      nxt.xbits = div_q[k-1].xbits << 1;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_q[k].valid <= 1'b0;
      end else if (advance) begin
        div_q[k] <= nxt;
      end
    end
  end

  // Direction times t.
  logic                     m_valid, m_hit;
  logic [CoordW-1:0]        m_t;
  logic [2:0][CoordW-1:0]   m_origin;
  logic signed [TProdW-1:0] m_p0, m_p1, m_p2;
  logic [CoordW-1:0]        t_sel;

  assign t_sel = div_q[DivSteps].sat ? DistMax : {1'b0, div_q[DivSteps].quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= div_q[DivSteps].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_hit    <= div_q[DivSteps].hit;
      m_t      <= t_sel;
      m_origin <= div_q[DivSteps].ray.origin;
      m_p0 <= $signed(div_q[DivSteps].ray.dir[0]) * $signed({1'b0, t_sel});
      m_p1 <= $signed(div_q[DivSteps].ray.dir[1]) * $signed({1'b0, t_sel});
      m_p2 <= $signed(div_q[DivSteps].ray.dir[2]) * $signed({1'b0, t_sel});
    end
  end

  function automatic logic [CoordW-1:0] point_sat(input logic [CoordW-1:0] o,
                                                   input logic signed [TProdW-1:0] p);
    logic signed [SumW-1:0] s;
    s = SumW'($signed(o)) + SumW'(p >>> 16);
    if (s > SumW'(32'sh7FFF_FFFF)) begin
      point_sat = 32'h7FFF_FFFF;
    end else if (s < SumW'(-33'sd2147483648)) begin
      point_sat = 32'h8000_0000;
    end else begin
      point_sat = s[CoordW-1:0];
    end
  endfunction

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.hit              <= m_hit;
      result.distance         <= m_hit ? m_t : '0;
      result.point_x          <= m_hit ? point_sat(m_origin[0], m_p0) : '0;
      result.point_y          <= m_hit ? point_sat(m_origin[1], m_p1) : '0;
      result.point_z          <= m_hit ? point_sat(m_origin[2], m_p2) : '0;
      result.surface_normal_x <= m_hit ? normal_x : '0;
      result.surface_normal_y <= m_hit ? normal_y : '0;
      result.surface_normal_z <= m_hit ? normal_z : '0;
    end
  end

`include "ray_plane_intersection_macros.svh"

  `RPI_ASSERT_IMPL(a_miss_zero, clk, rst, result.valid && !result.hit, result.distance == '0 && result.point_x == '0 && result.surface_normal_z == '0, "Miss result carries nonzero fields.")
  `RPI_ASSERT_IMPL(a_dist_nonneg, clk, rst, result.valid && result.hit, !result.distance[CoordW-1], "Hit distance is negative.")
  `RPI_ASSERT_NEXT(a_enter, clk, rst, ray.valid && ray.ready, s1_valid, "Accepted ray did not enter the pipeline.")

endmodule

/* tb/tb_ray_plane_intersection.sv */
// ----------------------------------------------------------------------------
// Ray/plane intersection testbench
// Drives rays through the valid/ready ray channel under several plane
// settings, predicts each result with an exact fixed-point plane model, and
// checks every result transfer in order against the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ray_plane_intersection;
  import rpi_pkg::*;

  localparam int DogLimit = 4000;
  localparam int HoldCycles = 300;
  localparam int Latency = 36;

  typedef struct {
    logic signed [CoordW-1:0] org[3];
    logic signed [CoordW-1:0] dir[3];
  } ray_item_t;

  typedef struct {
    logic                     hit;
    logic signed [CoordW-1:0] tdist;
    logic signed [CoordW-1:0] pt[3];
    logic signed [NormW-1:0]  nrm[3];
  } hit_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoordW-1:0] cfg_data = '0;

  rpi_ray_if ray ();
  rpi_hit_if result ();

  ray_plane_intersection i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .ray(ray.sink), .result(result.source)
  );

  logic signed [NormW-1:0] plane_n[3];
  logic signed [CoordW-1:0] plane_d;

  ray_item_t pending_rays[$];
  hit_item_t expected_hits[$];
  ray_item_t ray_on_bus;
  bit ray_taken = 0;
  bit no_idle = 0;
  bit hold_req = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  initial begin
    ray.valid = 1'b0;
    ray.origin_x = '0; ray.origin_y = '0; ray.origin_z = '0;
    ray.dir_x = '0; ray.dir_y = '0; ray.dir_z = '0;
    result.ready = 1'b0;
  end

  function automatic longint sat_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic hit_item_t intersect_plane(ray_item_t r);
    hit_item_t h;
    longint den, num, t;
    longint unsigned un, ud, q, rem, f;
    h.hit = 0; h.tdist = '0;
    for (int k = 0; k < 3; k++) begin
      h.pt[k] = '0; h.nrm[k] = '0;
    end
    den = 0; num = 0;
    for (int k = 0; k < 3; k++) begin
      den += longint'(plane_n[k]) * longint'(r.dir[k]);
      num += longint'(plane_n[k]) * longint'(r.org[k]);
    end
    num = -(num + longint'(plane_d) * 32768);
    if (den * 1000 + 64'sd2147483648 >= 0) return h;
    if (num > 0) return h;
    un = -num; ud = -den;
    q = un / ud; rem = un % ud; f = 0;
    if (q >= 32768) begin
      t = 64'sd2147483647;
    end else begin
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1; f = f << 1;
        if (rem >= ud) begin
          rem -= ud; f |= 1;
        end
      end
      t = longint'((q << 16) | f);
    end
    h.hit = 1; h.tdist = t[31:0];
    for (int k = 0; k < 3; k++) begin
      h.pt[k] = CoordW'(sat_coord(longint'(r.org[k]) + ((longint'(r.dir[k]) * t) >>> 16)));
      h.nrm[k] = plane_n[k];
    end
    return h;
  endfunction

  // Ray driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (!rst && (ray_taken || !ray.valid)) begin
      ray_taken = 0;
      if (pending_rays.size() > 0 && (no_idle || $urandom_range(99) >= 20)) begin
        ray_on_bus = pending_rays.pop_front();
        ray.origin_x <= ray_on_bus.org[0];
        ray.origin_y <= ray_on_bus.org[1];
        ray.origin_z <= ray_on_bus.org[2];
        ray.dir_x <= ray_on_bus.dir[0];
        ray.dir_y <= ray_on_bus.dir[1];
        ray.dir_z <= ray_on_bus.dir[2];
        ray.valid <= 1'b1;
      end else begin
        ray.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && ray.valid && ray.ready) begin
      ray_taken = 1;
      expected_hits.push_back(intersect_plane(ray_on_bus));
    end
  end

  // Result sink: ready changes on the falling edge, long hold on request.
  always @(negedge clk) begin
    if (hold_req) begin
      result.ready <= 1'b0;
      for (int i = 0; i < HoldCycles; i++) @(negedge clk);
      hold_req = 0;
    end else begin
      result.ready <= !rst && (no_idle || $urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin
    hit_item_t exp_h, got;
    if (!rst && result.valid && result.ready) begin
      got.hit = result.hit; got.tdist = result.distance;
      got.pt[0] = result.point_x; got.pt[1] = result.point_y;
      got.pt[2] = result.point_z;
      got.nrm[0] = result.surface_normal_x; got.nrm[1] = result.surface_normal_y;
      got.nrm[2] = result.surface_normal_z;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result transfer with nothing expected");
      end else begin
        exp_h = expected_hits.pop_front();
        if (got.hit !== exp_h.hit || got.tdist !== exp_h.tdist ||
            got.pt[0] !== exp_h.pt[0] || got.pt[1] !== exp_h.pt[1] ||
            got.pt[2] !== exp_h.pt[2] || got.nrm[0] !== exp_h.nrm[0] ||
            got.nrm[1] !== exp_h.nrm[1] || got.nrm[2] !== exp_h.nrm[2]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected hit=%0d t=%h p=%h %h %h n=%h %h %h",
                     exp_h.hit, exp_h.tdist, exp_h.pt[0], exp_h.pt[1], exp_h.pt[2],
                     exp_h.nrm[0], exp_h.nrm[1], exp_h.nrm[2]);
            $display("          actual   hit=%0d t=%h p=%h %h %h n=%h %h %h",
                     got.hit, got.tdist, got.pt[0], got.pt[1], got.pt[2],
                     got.nrm[0], got.nrm[1], got.nrm[2]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (ray.valid && ray.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= DogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [CoordW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_PLANE_OFFSET) plane_d = value;
    else plane_n[idx] = value[NormW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_plane(logic [NormW-1:0] x, logic [NormW-1:0] y,
                           logic [NormW-1:0] z, logic [CoordW-1:0] d);
    write_reg(REG_NORMAL_X, {{(CoordW-NormW){x[NormW-1]}}, x});
    write_reg(REG_NORMAL_Y, {{(CoordW-NormW){y[NormW-1]}}, y});
    write_reg(REG_NORMAL_Z, {{(CoordW-NormW){z[NormW-1]}}, z});
    write_reg(REG_PLANE_OFFSET, d);
  endtask

  task automatic drain();
    while (pending_rays.size() > 0 || ray.valid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    logic signed [CoordW-1:0] v;
    v = $signed($urandom);
    return v >>> $urandom_range(31);
  endfunction

  function automatic logic signed [CoordW-1:0] flip(logic signed [CoordW-1:0] v);
    return (v == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v;
  endfunction

  function automatic ray_item_t make_ray(logic signed [CoordW-1:0] ox,
      logic signed [CoordW-1:0] oy, logic signed [CoordW-1:0] oz,
      logic signed [CoordW-1:0] dx, logic signed [CoordW-1:0] dy,
      logic signed [CoordW-1:0] dz);
    ray_item_t r;
    r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
    r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
    return r;
  endfunction

  task automatic random_rays(int count);
    ray_item_t r;
    hit_item_t h;
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) begin
        r.org[k] = rand_coord();
        r.dir[k] = rand_coord();
      end
      // Most rays are steered toward the front of the plane.
      if ($urandom_range(99) < 75) begin
        h = intersect_plane(r);
        if (!h.hit)
          for (int k = 0; k < 3; k++) r.dir[k] = flip(r.dir[k]);
        h = intersect_plane(r);
        if (!h.hit)
          for (int k = 0; k < 3; k++) r.org[k] = flip(r.org[k]);
      end
      pending_rays.push_back(r);
    end
  endtask

  initial begin
    logic signed [CoordW-1:0] mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    plane_n[0] = '0; plane_n[1] = '0; plane_n[2] = NormalZReset; plane_d = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset plane z = 0 facing +z.
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, -65536));
    pending_rays.push_back(make_ray(100, -7, 65536, 3, 5, -65536));
    pending_rays.push_back(make_ray(1, 2, 65536, 0, 0, -1));
    pending_rays.push_back(make_ray(1, 2, 65536, 0, 0, -66));
    pending_rays.push_back(make_ray(1, 2, 65536, 0, 0, -65));
    pending_rays.push_back(make_ray(1, 2, 65536, 0, 0, 0));
    pending_rays.push_back(make_ray(1, 2, 65536, 0, 0, 65536));
    pending_rays.push_back(make_ray(1, 2, -65536, 0, 0, -65536));
    pending_rays.push_back(make_ray(0, 0, mx, 0, 0, -66));
    pending_rays.push_back(make_ray(mx, mn, mx, mx, mn, -65536));
    pending_rays.push_back(make_ray(mn, mx, 65536 * 100, mn, mx, -65536));
    pending_rays.push_back(make_ray(mx, mx, mx, mx, mx, mn));
    pending_rays.push_back(make_ray(mn, mn, mn, mn, mn, mn));
    pending_rays.push_back(make_ray(mx, mx, mx, mx, mx, mx));
    pending_rays.push_back(make_ray(-5, 9, 3 * 65536, 65536, -65536, -2 * 65536));
    pending_rays.push_back(make_ray(0, 0, 7, 0, 0, mn));
    drain();

    set_plane(17'sd32768, 17'sd0, 17'sd0, mn);
    random_rays(150);
    drain();

    set_plane(-17'sd32768, 17'sd0, 17'sd0, mx);
    hold_req = 1;
    random_rays(150);
    drain();

    set_plane(17'sd0, -17'sd32768, 17'sd0, $urandom);
    no_idle = 1;
    random_rays(150);
    drain();
    no_idle = 0;

    for (int p = 0; p < 3; p++) begin
      set_plane(NormW'($urandom_range(46340) - 23170),
                NormW'($urandom_range(46340) - 23170),
                NormW'($urandom_range(46340) - 23170), rand_coord());
      random_rays(150);
      drain();
    end

    for (int p = 0; p < 2; p++) begin
      set_plane(NormW'($urandom), NormW'($urandom), NormW'($urandom), $urandom);
      random_rays(150);
      drain();
    end

    set_plane(17'sd0, 17'sd0, 17'sd0, 32'sd0);
    random_rays(30);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
